FILE: src/mpec_pkg.sv
// Shared types, constants and helpers for the MBR partition entry checker.
// No dependencies; used by every module under src.
package mpec_pkg;

    localparam logic [7:0] TYPE_EMPTY  = 8'h00;
    localparam logic [7:0] TYPE_EXT_A  = 8'h05;
    localparam logic [7:0] TYPE_EXT_B  = 8'h0f;
    localparam logic [7:0] TYPE_EXT_C  = 8'h85;
    localparam logic [6:0] ACTIVE_MASK = 7'h7f;
    localparam logic [9:0] CYL_MAX     = 10'h3ff;
    localparam logic [23:0] CHS_OVER   = 24'hffffff;

    localparam logic [1:0] CODE_OK     = 2'd0;
    localparam logic [1:0] CODE_SECTOR = 2'd1;
    localparam logic [1:0] CODE_HEAD   = 2'd2;

    localparam logic [1:0] REG_GEO     = 2'd0;
    localparam logic [1:0] REG_HEADS   = 2'd1;
    localparam logic [1:0] REG_SPT     = 2'd2;

    localparam int DIV_W  = 32;
    localparam int DSR_W  = 14;

    typedef struct packed {
        logic        geo_valid;
        logic [7:0]  heads;
        logic [5:0]  spt;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  slot;
        logic [31:0] table_sector;
        logic [31:0] extended_base;
        logic [31:0] table_length;
        logic [7:0]  active_byte;
        logic [7:0]  type_id;
        logic [23:0] first_chs;
        logic [23:0] end_chs;
        logic [31:0] raw_start;
        logic [31:0] raw_length;
    } item_t;

    // front -> back queue payload
    typedef struct packed {
        logic [1:0]  slot;
        logic [31:0] abs_start;
        logic [31:0] abs_end;
        logic        active_odd;
        logic        past_end;
        logic [1:0]  head_code;
        logic [2:0]  overlap;
        logic [23:0] first_chs;
        logic [23:0] end_chs;
    } entry_t;

    typedef struct packed {
        logic [23:0] exp_end;
        logic [23:0] exp_start;
        logic [2:0]  overlap;
        logic        end_mm;
        logic        start_mm;
        logic        end_cyl_warn;
        logic [1:0]  head_code;
        logic        past_end;
        logic        active_odd;
        logic [31:0] abs_end;
        logic [31:0] abs_start;
        logic [1:0]  slot;
    } result_t;

    function automatic logic is_ext(input logic [7:0] t);
        return (t == TYPE_EXT_A) || (t == TYPE_EXT_B) || (t == TYPE_EXT_C);
    endfunction

endpackage

FILE: src/mpec_front.sv
// Front end: accepts entries, computes LBA range, simple flags and overlap mask.
// Depends on mpec_pkg.
module mpec_front (
    input  logic                clk,
    input  logic                in_valid,
    output logic                in_ready,
    input  mpec_pkg::item_t     item,
    input  logic                q_full,
    output logic                q_push,
    output mpec_pkg::entry_t    q_data
);

    logic [31:0] rs_reg [3];
    logic [31:0] rl_reg [3];
    logic        accept;
    logic        ext;
    logic [31:0] st;
    logic [31:0] en;
    logic [31:0] span;
    logic [2:0]  mask;
    logic [31:0] lim;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (item.type_id != mpec_pkg::TYPE_EMPTY);

    // earlier-slot store, undefined until written
    always_ff @(posedge clk)
    begin
        if (accept && (item.slot != 2'd3))
        begin
            rs_reg[item.slot] <= item.raw_start;
            rl_reg[item.slot] <= item.raw_length;
        end
    end

    always_comb
    begin
        ext  = mpec_pkg::is_ext(item.type_id);
        st   = item.raw_start + (ext ? item.extended_base : item.table_sector);
        en   = st + item.raw_length - 32'd1;
        span = item.table_sector + item.table_length;
        mask = '0;
        for (int j = 0; j < 3; j++)
        begin
            lim = rs_reg[j] + rl_reg[j];
            if ((2'(j) < item.slot) &&
                ((st >= rs_reg[j] && st < lim) || (en >= rs_reg[j] && en < lim)))
            begin
                mask[j] = 1'b1;
            end
        end
        q_data.slot       = item.slot;
        q_data.abs_start  = st;
        q_data.abs_end    = en;
        q_data.active_odd = (item.active_byte[6:0] & mpec_pkg::ACTIVE_MASK) != 7'd0;
        q_data.past_end   = (en >= span) && !ext;
        if (item.first_chs[13:8] != 6'd1)
            q_data.head_code = mpec_pkg::CODE_SECTOR;
        else if (item.first_chs[7:0] > 8'd1)
            q_data.head_code = mpec_pkg::CODE_HEAD;
        else
            q_data.head_code = mpec_pkg::CODE_OK;
        q_data.overlap    = mask;
        q_data.first_chs  = item.first_chs;
        q_data.end_chs    = item.end_chs;
    end

endmodule

FILE: src/mpec_queue.sv
// Two-entry queue between front and back ends.
// Depends on mpec_pkg.
module mpec_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mpec_pkg::entry_t    push_data,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output mpec_pkg::entry_t    head
);

    mpec_pkg::entry_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

FILE: src/mpec_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend, 14-bit divisor.
// Depends on mpec_pkg.
module mpec_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mpec_pkg::DIV_W-1:0]   dividend,
    input  logic [mpec_pkg::DSR_W-1:0]   divisor,
    output logic                         done,
    output logic [mpec_pkg::DIV_W-1:0]   quotient,
    output logic [mpec_pkg::DSR_W-1:0]   remainder
);

    logic [mpec_pkg::DIV_W-1:0] quo_reg;
    logic [mpec_pkg::DSR_W-1:0] rem_reg;
    logic [mpec_pkg::DSR_W-1:0] dsr_reg;
    logic [5:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [mpec_pkg::DSR_W:0]   trial;
    logic [mpec_pkg::DSR_W:0]   diff;

    assign trial     = {rem_reg, quo_reg[mpec_pkg::DIV_W-1]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(mpec_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[mpec_pkg::DSR_W])
            begin
                rem_reg <= diff[mpec_pkg::DSR_W-1:0];
                quo_reg <= {quo_reg[mpec_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[mpec_pkg::DSR_W-1:0];
                quo_reg <= {quo_reg[mpec_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: src/mpec_back.sv
// Back end: CHS/LBA checks and expected CHS through the shared divider.
// Depends on mpec_pkg and mpec_div.
module mpec_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mpec_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  mpec_pkg::entry_t    q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output mpec_pkg::result_t   out_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL_A  = 3'd1;
    localparam logic [2:0] S_MUL_B  = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        state_reg;
    logic              sel_reg;
    logic              phase_reg;
    mpec_pkg::entry_t  ent_reg;
    logic              geo_reg;
    logic              ecw_reg;
    logic [1:0]        mm_reg;
    logic [13:0]       hs_reg;
    logic [18:0]       prod_reg;
    logic [7:0]        cyl_lo_reg;
    logic [1:0]        cyl_hi_reg;
    logic              cyl_big_reg;
    logic [23:0]       exp_reg [2];
    logic              out_valid_reg;
    mpec_pkg::result_t out_reg;

    logic              geo;
    logic [23:0]       chs;
    logic [31:0]       lba_val;
    logic [9:0]        cyl;
    logic [31:0]       conv;
    logic              div_start;
    logic              div_done;
    logic [31:0]       div_q;
    logic [13:0]       div_r;
    logic [31:0]       div_a;
    logic [13:0]       div_b;
    logic [5:0]        sect;

    assign geo       = cfg.geo_valid && (cfg.heads != 8'd0) && (cfg.spt != 6'd0);
    assign chs       = sel_reg ? ent_reg.end_chs : ent_reg.first_chs;
    assign lba_val   = sel_reg ? ent_reg.abs_end : ent_reg.abs_start;
    assign cyl       = {chs[15:14], chs[23:16]};
    assign conv      = 32'(prod_reg * cfg.spt) + {26'd0, chs[13:8]} - 32'd1;
    assign div_start = (state_reg == S_DSTART);
    assign div_a     = phase_reg ? {18'd0, div_r} : lba_val;
    assign div_b     = phase_reg ? {8'd0, cfg.spt} : hs_reg;
    assign sect      = div_r[5:0] + 6'd1;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    mpec_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    sel_reg   <= 1'b0;
                    phase_reg <= 1'b0;
                    if (q_valid)
                        state_reg <= geo ? S_MUL_A : S_DONE;
                end
                S_MUL_A:
                    state_reg <= S_MUL_B;
                S_MUL_B:
                begin
                    sel_reg   <= !sel_reg;
                    state_reg <= sel_reg ? S_DSTART : S_MUL_A;
                end
                S_DSTART:
                    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        phase_reg <= !phase_reg;
                        if (phase_reg)
                        begin
                            sel_reg   <= !sel_reg;
                            state_reg <= sel_reg ? S_DONE : S_DSTART;
                        end
                        else
                        begin
                            state_reg <= S_DSTART;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ent_reg <= q_head;
                geo_reg <= geo;
                hs_reg  <= 14'(cfg.heads * cfg.spt);
                ecw_reg <= geo && (q_head.end_chs[7:0] != (cfg.heads - 8'd1)) &&
                           (q_head.end_chs[13:8] != cfg.spt);
                mm_reg  <= 2'b00;
            end
            S_MUL_A:
                prod_reg <= 19'(cyl * cfg.heads) + {11'd0, chs[7:0]};
            S_MUL_B:
                mm_reg[sel_reg] <= (conv != lba_val);
            S_DWAIT:
            begin
                if (div_done && !phase_reg)
                begin
                    cyl_big_reg <= (div_q > {22'd0, mpec_pkg::CYL_MAX});
                    cyl_lo_reg  <= div_q[7:0];
                    cyl_hi_reg  <= div_q[9:8];
                end
                if (div_done && phase_reg)
                begin
                    exp_reg[sel_reg] <= cyl_big_reg ? mpec_pkg::CHS_OVER :
                        {cyl_lo_reg, cyl_hi_reg, sect, div_q[7:0]};
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.slot         <= ent_reg.slot;
                    out_reg.abs_start    <= ent_reg.abs_start;
                    out_reg.abs_end      <= ent_reg.abs_end;
                    out_reg.active_odd   <= ent_reg.active_odd;
                    out_reg.past_end     <= ent_reg.past_end;
                    out_reg.head_code    <= ent_reg.head_code;
                    out_reg.end_cyl_warn <= ecw_reg;
                    out_reg.start_mm     <= mm_reg[0];
                    out_reg.end_mm       <= mm_reg[1];
                    out_reg.overlap      <= ent_reg.overlap;
                    out_reg.exp_start    <= geo_reg ? exp_reg[0] : 24'd0;
                    out_reg.exp_end      <= geo_reg ? exp_reg[1] : 24'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: src/mbr_partition_entry_checker_top.sv
// MBR partition entry checker: one partition table entry per input transaction;
// a result transaction for every non-empty entry, flags, overlap mask and
// expected CHS. The front end takes an entry and queues it (two deep). When
// geometry is off the back end pops the entry and loads the result; when it is
// on, it pops the entry, runs four CHS/LBA multiply steps, makes four passes of
// the shared one-bit-per-cycle divider (start, 32 steps, done) for start
// cylinder, start head, end cylinder and end head, and loads the result. The
// result then sits in the output register until taken. Empty entries (type 0)
// only update the slot store and produce no result. Slots of one table are fed
// 0 to 3 in order; slot 3 is checked but not stored. Configuration (geometry
// valid at 0x0, heads per cylinder at 0x4, sectors per track at 0x8) is to be
// written over APB only while the block is idle; the block does not enforce it.
// Depends on mpec_pkg and all mpec_*.
module mbr_partition_entry_checker_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // low to high: slot, table_sector, extended_base, table_length, active_byte,
    // type_id, start CHS, end_chs, raw_start, raw_length, 6 zero bits
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // low to high: entry_slot, abs_start, abs_end, active_odd, past_end,
    // start_head_code, end_cyl_warn, start_mismatch, end_mismatch, overlap_mask,
    // expected start CHS, expected end CHS, 4 zero bits
    output logic [127:0] m_tdata
);

    mpec_pkg::cfg_t    cfg_reg;
    mpec_pkg::item_t   item;
    mpec_pkg::entry_t  push_data;
    mpec_pkg::entry_t  q_head;
    mpec_pkg::result_t res;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_valid;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.geo_valid <= 1'b0;
            cfg_reg.heads     <= 8'd255;
            cfg_reg.spt       <= 6'd63;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                mpec_pkg::REG_GEO:   cfg_reg.geo_valid <= pwdata[0];
                mpec_pkg::REG_HEADS: cfg_reg.heads     <= pwdata[7:0];
                mpec_pkg::REG_SPT:   cfg_reg.spt       <= pwdata[5:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mpec_pkg::REG_GEO:   prdata = {31'd0, cfg_reg.geo_valid};
            mpec_pkg::REG_HEADS: prdata = {24'd0, cfg_reg.heads};
            mpec_pkg::REG_SPT:   prdata = {26'd0, cfg_reg.spt};
            default:             prdata = 32'd0;
        endcase
    end

    // unpack the input transaction
    assign item.slot          = s_tdata[1:0];
    assign item.table_sector  = s_tdata[33:2];
    assign item.extended_base = s_tdata[65:34];
    assign item.table_length  = s_tdata[97:66];
    assign item.active_byte   = s_tdata[105:98];
    assign item.type_id       = s_tdata[113:106];
    assign item.first_chs     = s_tdata[137:114];
    assign item.end_chs       = s_tdata[161:138];
    assign item.raw_start     = s_tdata[193:162];
    assign item.raw_length    = s_tdata[225:194];

    mpec_front u_front (
        .clk      (clk),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .item     (item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    mpec_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    mpec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // result_t is declared high field first, so it packs low field first
    assign m_tdata = {4'd0, res};

endmodule

FILE: tb/mpec_checker.sv
// Watches the entry and result streams of the MBR partition entry checker,
// predicts each result and compares it field by field.
// Depends on mpec_pkg; configuration is mirrored from the APB write strobes.
module mpec_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [231:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        geo_on;
    logic [7:0]  heads;
    logic [5:0]  spt;
    logic [31:0] slot_start [3];
    logic [31:0] slot_len   [3];
    mpec_pkg::result_t expected_results[$];

    function automatic logic [31:0] chs_lba(input logic [23:0] p);
        logic [31:0] c;
        c = {22'd0, p[15:14], p[23:16]};
        return (c * heads + p[7:0]) * spt + p[13:8] - 32'd1;
    endfunction

    function automatic logic [23:0] lba_chs(input logic [31:0] lba);
        logic [31:0] hs, c, t, h, s;
        hs = heads * spt;
        c = lba / hs;
        t = lba % hs;
        h = t / spt;
        s = t % spt + 1;
        if (c > mpec_pkg::CYL_MAX)
            return mpec_pkg::CHS_OVER;
        return {c[7:0], c[9:8] + 2'd0 == 2'd0 ? 2'b00 : c[9:8], s[5:0], h[7:0]};
    endfunction

    function automatic mpec_pkg::result_t predict_entry(input mpec_pkg::item_t it);
        mpec_pkg::result_t r;
        logic    ext, geo;
        logic [31:0] lim;
        r = '0;
        ext = mpec_pkg::is_ext(it.type_id);
        r.slot = it.slot;
        r.abs_start = it.raw_start + (ext ? it.extended_base : it.table_sector);
        r.abs_end = r.abs_start + it.raw_length - 32'd1;
        r.active_odd = |it.active_byte[6:0];
        r.past_end = !ext && (r.abs_end >= it.table_sector + it.table_length);
        if (it.first_chs[13:8] != 6'd1)
            r.head_code = mpec_pkg::CODE_SECTOR;
        else if (it.first_chs[7:0] > 8'd1)
            r.head_code = mpec_pkg::CODE_HEAD;
        else
            r.head_code = mpec_pkg::CODE_OK;
        geo = geo_on && heads != 0 && spt != 0;
        if (geo)
        begin
            r.end_cyl_warn = (it.end_chs[7:0] != heads - 8'd1)
                && (it.end_chs[13:8] != spt);
            r.start_mm = chs_lba(it.first_chs) != r.abs_start;
            r.end_mm = chs_lba(it.end_chs) != r.abs_end;
            r.exp_start = lba_chs(r.abs_start);
            r.exp_end = lba_chs(r.abs_end);
        end
        for (int j = 0; j < 3; j++)
        begin
            lim = slot_start[j] + slot_len[j];
            if (j < it.slot && ((r.abs_start >= slot_start[j] && r.abs_start < lim)
                || (r.abs_end >= slot_start[j] && r.abs_end < lim)))
                r.overlap[j] = 1'b1;
        end
        return r;
    endfunction

    // tdata packs the first field lowest, so map it by hand
    function automatic mpec_pkg::result_t unpack_result(input logic [127:0] d);
        mpec_pkg::result_t r;
        r.slot = d[1:0];
        r.abs_start = d[33:2];
        r.abs_end = d[65:34];
        r.active_odd = d[66];
        r.past_end = d[67];
        r.head_code = d[69:68];
        r.end_cyl_warn = d[70];
        r.start_mm = d[71];
        r.end_mm = d[72];
        r.overlap = d[75:73];
        r.exp_start = d[99:76];
        r.exp_end = d[123:100];
        return r;
    endfunction

    function automatic mpec_pkg::item_t unpack_entry(input logic [231:0] d);
        mpec_pkg::item_t it;
        it.slot = d[1:0];
        it.table_sector = d[33:2];
        it.extended_base = d[65:34];
        it.table_length = d[97:66];
        it.active_byte = d[105:98];
        it.type_id = d[113:106];
        it.first_chs = d[137:114];
        it.end_chs = d[161:138];
        it.raw_start = d[193:162];
        it.raw_length = d[225:194];
        return it;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mpec_pkg::item_t   it;
        mpec_pkg::result_t e, a;
        if (!rst_n)
        begin
            geo_on = 1'b0;
            heads = 8'd255;
            spt = 6'd63;
            errors = 0;
            for (int j = 0; j < 3; j++)
            begin
                slot_start[j] = '0;
                slot_len[j] = '0;
            end
            expected_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == 4 * mpec_pkg::REG_GEO)
                    geo_on = pwdata[0];
                else if (paddr == 4 * mpec_pkg::REG_HEADS)
                    heads = pwdata[7:0];
                else if (paddr == 4 * mpec_pkg::REG_SPT)
                    spt = pwdata[5:0];
            end
            if (m_tvalid && m_tready)
            begin
                a = unpack_result(m_tdata);
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("entry_slot", e.slot, a.slot);
                    check_field("abs_start", e.abs_start, a.abs_start);
                    check_field("abs_end", e.abs_end, a.abs_end);
                    check_field("active_odd", e.active_odd, a.active_odd);
                    check_field("past_end", e.past_end, a.past_end);
                    check_field("start_head_code", e.head_code, a.head_code);
                    check_field("end_cyl_warn", e.end_cyl_warn, a.end_cyl_warn);
                    check_field("start_mismatch", e.start_mm, a.start_mm);
                    check_field("end_mismatch", e.end_mm, a.end_mm);
                    check_field("overlap_mask", e.overlap, a.overlap);
                    check_field("exp_start", e.exp_start, a.exp_start);
                    check_field("exp_end", e.exp_end, a.exp_end);
                end
            end
            if (s_tvalid && s_tready)
            begin
                it = unpack_entry(s_tdata);
                if (it.type_id != mpec_pkg::TYPE_EMPTY)
                    expected_results.push_back(predict_entry(it));
                if (it.slot < 2'd3)
                begin
                    slot_start[it.slot] = it.raw_start;
                    slot_len[it.slot] = it.raw_length;
                end
            end
        end
        pending = expected_results.size();
    end
endmodule

FILE: tb/testbench.sv
// Stimulus and verdict for the MBR partition entry checker: APB geometry setup,
// partition tables of four entries per stream, random flow control.
// Depends on mpec_pkg, mbr_partition_entry_checker_top and mpec_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 20000;  // cycles with no transaction at all
    localparam int DRAIN_WAIT  = 400;    // slack after the last expected result

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [231:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    int           errors;
    int           pending;

    // idle percentages of the sender and the receiver, and the long hold-off
    int           send_idle_pct = 19;
    int           recv_idle_pct = 57;
    int           recv_hold = 0;
    int           quiet_cycles = 0;

    always #5 clk = ~clk;

    mbr_partition_entry_checker_top u_dut (.*);

    mpec_checker u_chk (.*);

    // receiver: random stalls plus an explicit hold-off counter
    always @(posedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on accepted transactions of either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait until all results are in, plus slack for an empty entry in flight
    task automatic wait_idle();
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_geometry(input logic g, input logic [7:0] h, input logic [5:0] s);
        wait_idle();
        apb_write(mpec_pkg::REG_GEO, {31'd0, g});
        apb_write(mpec_pkg::REG_HEADS, {24'd0, h});
        apb_write(mpec_pkg::REG_SPT, {26'd0, s});
    endtask

    task automatic send_entry(input mpec_pkg::item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, it.raw_length, it.raw_start, it.end_chs, it.first_chs,
                    it.type_id, it.active_byte, it.table_length, it.extended_base,
                    it.table_sector, it.slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [23:0] pack_chs(input int c, input int h, input int s);
        return {c[7:0], c[9:8], s[5:0], h[7:0]};
    endfunction

    function automatic logic [7:0] rand_type();
        case ($urandom_range(9))
            0: return mpec_pkg::TYPE_EXT_A;
            1: return mpec_pkg::TYPE_EXT_B;
            2: return mpec_pkg::TYPE_EXT_C;
            3: return mpec_pkg::TYPE_EMPTY;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one table of four slots; mostly consistent geometry, some noise
    task automatic send_table(input logic [7:0] h, input logic [5:0] s);
        mpec_pkg::item_t it;
        int    hh, ss, base;
        logic [31:0] cursor;
        hh = (h == 0) ? 1 : h;
        ss = (s == 0) ? 1 : s;
        base = $urandom_range(3) == 0 ? $urandom : $urandom_range(4000);
        cursor = $urandom_range(1) ? ss : $urandom_range(100000);
        for (int k = 0; k < 4; k++)
        begin
            it.slot = 2'(k);
            it.table_sector = base;
            it.extended_base = $urandom_range(1) ? base : $urandom;
            it.table_length = $urandom_range(7) == 0 ? $urandom : 32'd3000000;
            it.active_byte = $urandom_range(1) ? 8'h00 :
                             ($urandom_range(1) ? 8'h80 : 8'($urandom_range(255)));
            it.type_id = rand_type();
            it.raw_start = $urandom_range(4) == 0 ? $urandom : cursor;
            it.raw_length = $urandom_range(4) == 0 ? $urandom : $urandom_range(1, 200000);
            if ($urandom_range(3) != 0)
            begin
                int a, e;
                a = it.raw_start + it.table_sector;
                e = a + it.raw_length - 1;
                it.first_chs = pack_chs((a / (hh * ss)) % 1024, (a / ss) % hh, a % ss + 1);
                it.end_chs = pack_chs((e / (hh * ss)) % 1024, (e / ss) % hh, e % ss + 1);
            end
            else
            begin
                it.first_chs = 24'($urandom);
                it.end_chs = 24'($urandom);
            end
            cursor = $urandom_range(2) == 0 ? $urandom_range(300000) :
                     it.raw_start + it.raw_length;
            send_entry(it);
        end
    endtask

    // hand-picked tables covering field extremes and each flag
    task automatic directed_tables();
        mpec_pkg::item_t it;
        for (int k = 0; k < 4; k++)
        begin
            it.slot = 2'(k);
            it.table_sector = (k == 1) ? 32'hffffffff : 32'd0;
            it.extended_base = (k == 2) ? 32'hffffffff : 32'd0;
            it.table_length = (k == 3) ? 32'hffffffff : 32'd0;
            it.active_byte = (k == 0) ? 8'hff : (k == 1 ? 8'h80 : 8'h01);
            it.type_id = (k == 0) ? 8'hff : (k == 1 ? mpec_pkg::TYPE_EXT_A :
                         (k == 2 ? mpec_pkg::TYPE_EXT_B : mpec_pkg::TYPE_EXT_C));
            it.first_chs = (k == 0) ? 24'hffffff : (k == 1 ? 24'h000101 :
                           (k == 2 ? 24'h000102 : 24'h000000));
            it.end_chs = (k == 0) ? 24'hffffff : 24'd0;
            it.raw_start = (k == 3) ? 32'hffffffff : k * 32'd100;
            it.raw_length = (k == 0) ? 32'hffffffff : 32'd0;
            send_entry(it);
        end
        for (int k = 0; k < 4; k++)
        begin
            it = '0;
            it.slot = 2'(k);
            it.type_id = (k == 2) ? mpec_pkg::TYPE_EMPTY : 8'h83;
            it.raw_start = 32'd50 * k;
            it.raw_length = 32'd120;
            it.first_chs = 24'h000201;
            it.end_chs = 24'hfe3ffe;
            it.table_length = 32'd100;
            send_entry(it);
        end
    endtask

    task automatic random_phase(input int tables, input logic [7:0] h, input logic [5:0] s);
        for (int n = 0; n < tables; n++)
            send_table(h, s);
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_tables();
        s_tvalid <= 1'b0;
        set_geometry(1'b1, 8'd255, 6'd63);
        directed_tables();
        s_tvalid <= 1'b0;
        set_geometry(1'b1, 8'd1, 6'd1);
        random_phase(10, 8'd1, 6'd1);

        // long receiver hold-off so the input queue fills and back-pressures
        recv_hold = 3000;
        random_phase(10, 8'd16, 6'd63);

        set_geometry(1'b1, 8'd16, 6'd63);
        random_phase(60, 8'd16, 6'd63);
        set_geometry(1'b0, 8'd255, 6'd63);
        random_phase(40, 8'd255, 6'd63);

        send_idle_pct = 57;
        recv_idle_pct = 19;
        set_geometry(1'b1, 8'd255, 6'd63);
        random_phase(60, 8'd255, 6'd63);
        set_geometry(1'b1, 8'd0, 6'd0);
        random_phase(20, 8'd0, 6'd0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_geometry(1'b1, 8'($urandom_range(1, 255)), 6'($urandom_range(1, 63)));
        random_phase(60, u_chk_heads(), 6'd32);
        set_geometry(1'b1, 8'd128, 6'd32);
        random_phase(40, 8'd128, 6'd32);

        wait_idle();
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [7:0] u_chk_heads();
        return 8'd64;
    endfunction
endmodule

FILE: files.f
src/mpec_pkg.sv
src/mpec_front.sv
src/mpec_queue.sv
src/mpec_div.sv
src/mpec_back.sv
src/mbr_partition_entry_checker_top.sv
tb/mpec_checker.sv
tb/testbench.sv
